### design/pip_pkg.sv
`timescale 1ns / 1ps

package pip_pkg;

   localparam int MaxVertices  = 64;
   localparam int CoordBits    = 16;
   localparam int CountBits    = 7;
   localparam int VtxCntBits   = $clog2(MaxVertices + 1);
   localparam int DiffBits     = CoordBits + 1;
   localparam int ProdBits     = 2 * DiffBits;
   localparam int StageCount   = 2 * MaxVertices;
   localparam int InflightBits = $clog2(StageCount + 2);

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef logic signed [CoordBits-1:0] coord_type;

   // one query travelling down the chain
   typedef struct packed {
      logic                 valid;
      coord_type            x;
      coord_type            y;
      logic [CountBits-1:0] left;
      logic [CountBits-1:0] right;
   } query_type;

   // vertex load toward one cell
   typedef struct packed {
      logic      set_head;
      logic      set_tail;
      coord_type x;
      coord_type y;
      coord_type wrap_x;
      coord_type wrap_y;
   } vtx_wr_type;

endpackage

### design/pip_edge_cell.sv
`timescale 1ns / 1ps

module pip_edge_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               active,
   input  pip_pkg::vtx_wr_type wr,
   input  pip_pkg::query_type  in_q,
   output pip_pkg::query_type  out_q
);

   // edge endpoints, undefined until loaded
   logic signed [pip_pkg::CoordBits-1:0] x0_ff, y0_ff, x1_ff, y1_ff;

   logic signed [pip_pkg::CoordBits-1:0] qx, qy;
   logic signed [pip_pkg::DiffBits-1:0]  dy, dcy, dx, dcx;
   logic signed [pip_pkg::ProdBits-1:0]  p_in, q_in;
   logic                                 spans;

   // stage one registers
   pip_pkg::query_type                   s1_ff;
   logic                                 hit_ff;
   logic                                 dy_pos_ff;
   logic signed [pip_pkg::ProdBits-1:0]  p_ff, q_ff;

   // stage two register
   pip_pkg::query_type                   s2_ff;
   logic                                 is_left;
   logic [pip_pkg::CountBits-1:0]        left_in, right_in;

   always_ff @(posedge clock) begin
      if (wr.set_head) begin
         x0_ff <= wr.x;
         y0_ff <= wr.y;
         x1_ff <= wr.wrap_x;
         y1_ff <= wr.wrap_y;
      end else if (wr.set_tail) begin
         x1_ff <= wr.x;
         y1_ff <= wr.y;
      end
   end

   assign qx  = in_q.x;
   assign qy  = in_q.y;
   assign dy  = {y1_ff[pip_pkg::CoordBits-1], y1_ff} - {y0_ff[pip_pkg::CoordBits-1], y0_ff};
   assign dx  = {x1_ff[pip_pkg::CoordBits-1], x1_ff} - {x0_ff[pip_pkg::CoordBits-1], x0_ff};
   assign dcy = {qy[pip_pkg::CoordBits-1], qy} - {y0_ff[pip_pkg::CoordBits-1], y0_ff};
   assign dcx = {qx[pip_pkg::CoordBits-1], qx} - {x0_ff[pip_pkg::CoordBits-1], x0_ff};
   assign p_in  = dcy * dx;
   assign q_in  = dcx * dy;
   assign spans = (qy >= y0_ff && qy < y1_ff) || (qy >= y1_ff && qy < y0_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ff.valid <= in_q.valid;
      end
      if (advance) begin
         s1_ff.x     <= in_q.x;
         s1_ff.y     <= in_q.y;
         s1_ff.left  <= in_q.left;
         s1_ff.right <= in_q.right;
         hit_ff      <= active && spans;
         dy_pos_ff   <= (dy > 0);
         p_ff        <= p_in;
         q_ff        <= q_in;
      end
   end

   // intersection strictly left of the point
   assign is_left = dy_pos_ff ? (p_ff < q_ff) : (q_ff < p_ff);

   always_comb begin
      left_in  = s1_ff.left;
      right_in = s1_ff.right;
      if (hit_ff) begin
         if (is_left) begin
            left_in = s1_ff.left + pip_pkg::CountBits'(1);
         end else begin
            right_in = s1_ff.right + pip_pkg::CountBits'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.valid <= 1'b0;
      end else if (advance) begin
         s2_ff.valid <= s1_ff.valid;
      end
      if (advance) begin
         s2_ff.x     <= s1_ff.x;
         s2_ff.y     <= s1_ff.y;
         s2_ff.left  <= left_in;
         s2_ff.right <= right_in;
      end
   end

   assign out_q = s2_ff;

endmodule

### design/point_in_polygon_test.sv
`timescale 1ns / 1ps

// channel  | ports                                          | direction
// ---------+------------------------------------------------+----------
// request  | req_valid req_stall req_op req_coord_x/_y      | in
// response | rsp_valid rsp_stall rsp_is_inside rsp_left/    | out
//          |   right_crossings rsp_overflowed               |
//
// A query beat passes a chain of MaxVertices edge cells, two register
// stages per cell, then one output register. Queries enter one per cycle
// while the chain is not frozen. Clear and append beats are held until every
// query in the chain has been delivered; the unused op code is taken at once
// and dropped. Reset clears the vertex count, the overflow flag and all valid
// bits; the vertex store has no clearing pass. A stalled result freezes the
// whole chain.
module point_in_polygon_test (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic signed [pip_pkg::CoordBits-1:0] req_coord_x,
   input  logic signed [pip_pkg::CoordBits-1:0] req_coord_y,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_is_inside,
   output logic [pip_pkg::CountBits-1:0]       rsp_left_crossings,
   output logic [pip_pkg::CountBits-1:0]       rsp_right_crossings,
   output logic                                rsp_overflowed
);

   logic [pip_pkg::VtxCntBits-1:0]   count_ff, count_in;
   logic                             overflow_ff, overflow_in;
   logic [pip_pkg::InflightBits-1:0] inflight_ff, inflight_in;
   logic signed [pip_pkg::CoordBits-1:0] first_x_ff, first_y_ff;

   logic                             advance;
   logic                             is_query, is_load;
   logic                             accept, query_accept, rsp_accept;
   logic                             append_write;
   logic                             not_full;
   pip_pkg::coord_type               wrap_x, wrap_y;

   pip_pkg::query_type               link [0:pip_pkg::MaxVertices];
   pip_pkg::query_type               out_ff;
   logic                             out_valid_ff;

   // the chain moves whenever the output register can take a beat
   assign advance  = !out_valid_ff || !rsp_stall;
   assign is_query = (req_op == pip_pkg::OP_QUERY);
   assign is_load  = (req_op == pip_pkg::OP_CLEAR) || (req_op == pip_pkg::OP_APPEND);

   // hold loads until the chain is drained; hold queries while frozen
   assign req_stall    = is_load ? (inflight_ff != '0) : (is_query && !advance);
   assign accept       = req_valid && !req_stall;
   assign query_accept = accept && is_query;
   assign rsp_accept   = out_valid_ff && !rsp_stall;
   assign not_full     = (count_ff < pip_pkg::VtxCntBits'(pip_pkg::MaxVertices));
   assign append_write = accept && (req_op == pip_pkg::OP_APPEND) && not_full;

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (accept) begin
         unique case (req_op)
            pip_pkg::OP_CLEAR: begin
               count_in    = '0;
               overflow_in = 1'b0;
            end
            pip_pkg::OP_APPEND: begin
               if (not_full) begin
                  count_in = count_ff + pip_pkg::VtxCntBits'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      inflight_in = inflight_ff;
      if (query_accept && !rsp_accept) begin
         inflight_in = inflight_ff + pip_pkg::InflightBits'(1);
      end else if (!query_accept && rsp_accept) begin
         inflight_in = inflight_ff - pip_pkg::InflightBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
         inflight_ff <= '0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
         inflight_ff <= inflight_in;
      end
   end

   // keep the first vertex for the closing edge
   always_ff @(posedge clock) begin
      if (append_write && count_ff == '0) begin
         first_x_ff <= req_coord_x;
         first_y_ff <= req_coord_y;
      end
   end

   // the newest vertex closes back to the first one
   assign wrap_x = (count_ff == '0) ? req_coord_x : first_x_ff;
   assign wrap_y = (count_ff == '0) ? req_coord_y : first_y_ff;

   assign link[0].valid = query_accept;
   assign link[0].x     = req_coord_x;
   assign link[0].y     = req_coord_y;
   assign link[0].left  = '0;
   assign link[0].right = '0;

   for (genvar i = 0; i < pip_pkg::MaxVertices; i++) begin : g_cell
      pip_pkg::vtx_wr_type wr;
      logic                active;

      assign wr.set_head = append_write && (count_ff == pip_pkg::VtxCntBits'(i));
      assign wr.set_tail = append_write && (count_ff == pip_pkg::VtxCntBits'(i + 1));
      assign wr.x        = req_coord_x;
      assign wr.y        = req_coord_y;
      assign wr.wrap_x   = wrap_x;
      assign wr.wrap_y   = wrap_y;
      assign active      = (pip_pkg::VtxCntBits'(i) < count_ff);

      pip_edge_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .active  (active),
         .wr      (wr),
         .in_q    (link[i]),
         .out_q   (link[i+1])
      );
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= link[pip_pkg::MaxVertices].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= link[pip_pkg::MaxVertices];
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_left_crossings  = out_ff.left;
   assign rsp_right_crossings = out_ff.right;
   assign rsp_is_inside       = out_ff.left[0] && out_ff.right[0];
   assign rsp_overflowed      = overflow_ff;

`ifndef SYNTHESIS
   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= pip_pkg::InflightBits'(pip_pkg::StageCount + 1))
      else $error("more queries in flight than chain stages");

   a_load_on_empty: assert property (@(posedge clock) disable iff (reset)
      (accept && is_load) |-> (inflight_ff == '0))
      else $error("polygon changed while queries in flight");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pip_pkg::VtxCntBits'(pip_pkg::MaxVertices))
      else $error("vertex count beyond capacity");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_ff |-> (count_ff == pip_pkg::VtxCntBits'(pip_pkg::MaxVertices)))
      else $error("overflow flagged with room left");

   a_rsp_tracked: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (inflight_ff != '0))
      else $error("result without a tracked query");
`endif

endmodule

### dv/point_in_polygon_test_tb.sv
`timescale 1ns / 1ps

module point_in_polygon_test_tb;

   typedef pip_pkg::coord_type coord_type;

   localparam int MaxVertices  = pip_pkg::MaxVertices;
   localparam int CoordBits    = pip_pkg::CoordBits;
   localparam int CountBits    = pip_pkg::CountBits;
   localparam int ClockPeriod  = 20;
   // one query crosses every edge cell, two stages each, then the output register
   localparam int ChainLatency = 2 * MaxVertices + 1;
   localparam int QuietLimit   = 40000;
   localparam int PhaseBeats   = 360;

   // the fourth op code is accepted and dropped by the block
   localparam logic [1:0] OpUnused = 2'd3;
   localparam coord_type  CoordMin = {1'b1, {(CoordBits-1){1'b0}}};
   localparam coord_type  CoordMax = ~CoordMin;

   typedef struct {
      logic [1:0] op;
      coord_type  x;
      coord_type  y;
      bit         hold;   // hold this beat back until every query is answered
   } beat_type;

   typedef struct {
      bit                 is_in;
      bit [CountBits-1:0] left;
      bit [CountBits-1:0] right;
      bit                 ovf;
   } crossing_type;

   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 req_valid   = 1'b0;
   logic                 req_stall;
   logic [1:0]           req_op      = pip_pkg::OP_CLEAR;
   coord_type            req_coord_x = '0;
   coord_type            req_coord_y = '0;
   logic                 rsp_valid;
   logic                 rsp_stall   = 1'b0;
   logic                 rsp_is_inside;
   logic [CountBits-1:0] rsp_left_crossings;
   logic [CountBits-1:0] rsp_right_crossings;
   logic                 rsp_overflowed;

   beat_type     pending_beats[$];
   crossing_type due_results[$];

   int send_idle_pct    = 0;
   int stall_pct        = 0;
   int failures         = 0;
   int queries_sent     = 0;
   int queries_answered = 0;
   int quiet_cycles     = 0;

   // shadow copy of the polygon the block holds
   coord_type poly_x[MaxVertices];
   coord_type poly_y[MaxVertices];
   int        poly_count = 0;
   bit        poly_ovf   = 1'b0;

   point_in_polygon_test dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_op              (req_op),
      .req_coord_x         (req_coord_x),
      .req_coord_y         (req_coord_y),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_is_inside       (rsp_is_inside),
      .rsp_left_crossings  (rsp_left_crossings),
      .rsp_right_crossings (rsp_right_crossings),
      .rsp_overflowed      (rsp_overflowed)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // hold reset at the start, then release it for good
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Update the shadow polygon for one accepted beat; a query walks every
   // closed edge and queues the crossing counts the block should report.
   task automatic track_beat(input logic [1:0] op, input coord_type x, input coord_type y);
      crossing_type r;
      int           j, nl, nr;
      longint       px, py, x0, y0, x1, y1, dy, lhs, rhs;
      case (op)
         pip_pkg::OP_CLEAR: begin
            poly_count = 0;
            poly_ovf   = 1'b0;
         end
         pip_pkg::OP_APPEND: begin
            if (poly_count < MaxVertices) begin
               poly_x[poly_count] = x;
               poly_y[poly_count] = y;
               poly_count++;
            end else begin
               poly_ovf = 1'b1;
            end
         end
         pip_pkg::OP_QUERY: begin
            nl = 0;
            nr = 0;
            px = x;
            py = y;
            for (int i = 0; i < poly_count; i++) begin
               j  = (i + 1 < poly_count) ? i + 1 : 0;
               x0 = poly_x[i];
               y0 = poly_y[i];
               x1 = poly_x[j];
               y1 = poly_y[j];
               // half-open y span: a horizontal edge never counts
               if ((py >= y0 && py < y1) || (py >= y1 && py < y0)) begin
                  dy  = y1 - y0;
                  lhs = (py - y0) * (x1 - x0);
                  rhs = (px - x0) * dy;
                  // crossing exactly at the point counts to the right
                  if (dy > 0 ? (lhs < rhs) : (rhs < lhs))
                     nl++;
                  else
                     nr++;
               end
            end
            r.is_in = nl[0] && nr[0];
            r.left  = CountBits'(nl);
            r.right = CountBits'(nr);
            r.ovf   = poly_ovf;
            due_results = {due_results, r};
         end
         default: ;
      endcase
   endtask

   // Driver: advance to the next queued beat once the current one is taken.
   // Query and answer counts live here so the hold-off decision never races
   // with the monitor.
   always @(posedge clock) begin
      beat_type nxt;
      bit       settled;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall && req_op == pip_pkg::OP_QUERY)
            queries_sent++;
         if (rsp_valid && !rsp_stall)
            queries_answered++;
         // a stalled beat stays on the bus unchanged
         if (!req_valid || !req_stall) begin
            settled = (queries_sent == queries_answered);
            if (pending_beats.size() != 0 && (!pending_beats[0].hold || settled) &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               nxt = pending_beats.pop_front();
               req_valid   <= 1'b1;
               req_op      <= nxt.op;
               req_coord_x <= nxt.x;
               req_coord_y <= nxt.y;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: predict on every accepted request beat, then check the result
   // beat against the oldest prediction. Also drive the random result stall.
   always @(posedge clock) begin
      crossing_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            track_beat(req_op, req_coord_x, req_coord_y);
         if (rsp_valid && !rsp_stall) begin
            if (due_results.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("unexpected result beat: in=%0d left=%0d right=%0d ovf=%0d",
                           rsp_is_inside, rsp_left_crossings, rsp_right_crossings,
                           rsp_overflowed);
            end else begin
               want = due_results.pop_front();
               if (rsp_is_inside !== want.is_in || rsp_left_crossings !== want.left ||
                   rsp_right_crossings !== want.right || rsp_overflowed !== want.ovf) begin
                  failures++;
                  if (failures <= 10)
                     $display({"crossing mismatch: expected in=%0d left=%0d right=%0d ovf=%0d,",
                               " got in=%0d left=%0d right=%0d ovf=%0d"},
                              want.is_in, want.left, want.right, want.ovf,
                              rsp_is_inside, rsp_left_crossings, rsp_right_crossings,
                              rsp_overflowed);
               end
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog: drop the run if no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QuietLimit) begin
         $display("[point_in_polygon_test] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_beat(input logic [1:0] op, input coord_type x, input coord_type y,
                             input bit hold);
      beat_type b;
      b.op   = op;
      b.x    = x;
      b.y    = y;
      b.hold = hold;
      pending_beats = {pending_beats, b};
   endtask

   function automatic coord_type pick_coord(input int span);
      if (span >= 32767)
         return coord_type'($urandom());
      return coord_type'(int'($urandom_range(0, 2 * span)) - span);
   endfunction

   // One polygon session: usually a clear, then a run of appends, then a
   // burst of queries aimed near the polygon, with some stray unused codes.
   task automatic add_session(inout int queued);
      coord_type vx[$], vy[$];
      coord_type qx, qy;
      int        n, nq, span, sel, idx;
      bit        hold_first;
      hold_first = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) != 0) begin
         queue_beat(pip_pkg::OP_CLEAR, pick_coord(32767), pick_coord(32767), hold_first);
         hold_first = 1'b0;
         queued++;
      end
      // mostly modest polygons, a few degenerate ones, now and then a full store
      sel = $urandom_range(0, 19);
      if (sel == 0)
         n = $urandom_range(MaxVertices - 4, MaxVertices + 6);
      else if (sel < 3)
         n = $urandom_range(0, 2);
      else
         n = $urandom_range(3, 12);
      case ($urandom_range(0, 3))
         0:       span = 4;
         1:       span = 100;
         2:       span = 3000;
         default: span = 32767;
      endcase
      for (int k = 0; k < n; k++) begin
         vx = {vx, pick_coord(span)};
         vy = {vy, pick_coord(span)};
         queue_beat(pip_pkg::OP_APPEND, vx[k], vy[k], hold_first);
         hold_first = 1'b0;
         queued++;
      end
      nq = $urandom_range(4, 24);
      for (int k = 0; k < nq; k++) begin
         sel = $urandom_range(0, 9);
         if (sel < 2 && vx.size() != 0) begin
            // land on or right next to a vertex
            idx = $urandom_range(0, vx.size() - 1);
            qx  = coord_type'(int'(vx[idx]) + int'($urandom_range(0, 2)) - 1);
            qy  = coord_type'(int'(vy[idx]) + int'($urandom_range(0, 2)) - 1);
         end else if (sel == 2) begin
            qx = pick_coord(32767);
            qy = pick_coord(32767);
         end else begin
            qx = pick_coord(span);
            qy = pick_coord(span);
         end
         queue_beat(pip_pkg::OP_QUERY, qx, qy, hold_first);
         hold_first = 1'b0;
         queued++;
         if ($urandom_range(0, 29) == 0)
            queue_beat(OpUnused, pick_coord(32767), pick_coord(32767), 1'b0);
      end
   endtask

   initial begin
      int queued;

      // directed: empty and one-vertex polygons, a corner triangle at the
      // coordinate extremes, a horizontal edge, points on edges and vertices,
      // a dropped unused code, then a small square probed inside, on and outside its boundary
      queue_beat(pip_pkg::OP_QUERY,  coord_type'(0),      coord_type'(0),      1'b1);
      queue_beat(pip_pkg::OP_APPEND, CoordMin,            CoordMin,            1'b0);
      queue_beat(pip_pkg::OP_QUERY,  CoordMin,            CoordMin,            1'b0);
      queue_beat(pip_pkg::OP_APPEND, CoordMax,            CoordMin,            1'b0);
      queue_beat(pip_pkg::OP_QUERY,  coord_type'(0),      CoordMin,            1'b0);
      queue_beat(pip_pkg::OP_APPEND, CoordMax,            CoordMax,            1'b0);
      queue_beat(pip_pkg::OP_QUERY,  coord_type'(16000),  coord_type'(-16000), 1'b0);
      queue_beat(pip_pkg::OP_QUERY,  CoordMax,            coord_type'(0),      1'b0);
      queue_beat(pip_pkg::OP_QUERY,  CoordMin,            CoordMax,            1'b0);
      queue_beat(pip_pkg::OP_QUERY,  CoordMax,            CoordMax,            1'b0);
      queue_beat(pip_pkg::OP_QUERY,  CoordMin,            CoordMin,            1'b0);
      queue_beat(OpUnused,           coord_type'(-1),     coord_type'(-1),     1'b0);
      // hold the clear until every query above has been answered
      queue_beat(pip_pkg::OP_CLEAR,  coord_type'(0),      coord_type'(0),      1'b1);
      queue_beat(pip_pkg::OP_APPEND, coord_type'(-2),     coord_type'(-2),     1'b0);
      queue_beat(pip_pkg::OP_APPEND, coord_type'(2),      coord_type'(-2),     1'b0);
      queue_beat(pip_pkg::OP_APPEND, coord_type'(2),      coord_type'(2),      1'b0);
      queue_beat(pip_pkg::OP_APPEND, coord_type'(-2),     coord_type'(2),      1'b0);
      queue_beat(pip_pkg::OP_QUERY,  coord_type'(0),      coord_type'(0),      1'b0);
      queue_beat(pip_pkg::OP_QUERY,  coord_type'(-2),     coord_type'(0),      1'b0);
      queue_beat(pip_pkg::OP_QUERY,  coord_type'(2),      coord_type'(0),      1'b0);
      queue_beat(pip_pkg::OP_QUERY,  coord_type'(3),      coord_type'(0),      1'b0);
      queue_beat(pip_pkg::OP_QUERY,  coord_type'(0),      coord_type'(2),      1'b0);
      queue_beat(pip_pkg::OP_QUERY,  coord_type'(1),      coord_type'(-2),     1'b0);

      // random phases: free flow, slow sender, slow receiver, both a little slow
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 15; stall_pct = 15; end
         endcase
         queued = 0;
         while (queued < PhaseBeats)
            add_session(queued);
         // wait until the last beat of the phase is taken
         do @(negedge clock); while (pending_beats.size() != 0 || req_valid);
      end

      // drain: every prediction answered, then let the chain run dry
      do @(negedge clock); while (due_results.size() != 0);
      repeat (ChainLatency + 20) @(negedge clock);
      failures += due_results.size();

      if (failures == 0)
         $display("[point_in_polygon_test] OK");
      else
         $display("[point_in_polygon_test] ERROR");
      $finish;
   end

endmodule

### sim.f
design/pip_pkg.sv
design/pip_edge_cell.sv
design/point_in_polygon_test.sv
dv/point_in_polygon_test_tb.sv
